@@ rtl/core/audio_file_header_parser_defines.svh @@
// Assertion macros used by the sound file header parser controller.
`ifndef AUDIO_FILE_HEADER_PARSER_DEFINES_SVH
`define AUDIO_FILE_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AFHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("afhp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define AFHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("afhp assertion failed");

`endif

@@ rtl/core/afhp_pkg.sv @@
// Package with constants, tags, command type and a helper of the header parser.
package afhp_pkg;

    localparam int HEADER_CAPTURE = 54;
    localparam int ADDR_W         = $clog2(HEADER_CAPTURE);
    localparam int COUNT_W        = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
    localparam int WIN_BYTES      = 46;
    localparam logic [ADDR_W-1:0] RD_LAST = ADDR_W'(WIN_BYTES - 1);
    localparam int OUT_W          = 168;

    localparam logic [1:0] FMT_WAVE = 2'd0;
    localparam logic [1:0] FMT_AIFF = 2'd1;
    localparam logic [1:0] FMT_NEXT = 2'd2;
    localparam logic [1:0] FMT_NONE = 2'd3;

    localparam logic [31:0] TAG_RIFF = "RIFF";
    localparam logic [31:0] TAG_WAVE = "WAVE";
    localparam logic [31:0] TAG_FMT  = "fmt ";
    localparam logic [31:0] TAG_DATA = "data";
    localparam logic [31:0] TAG_FORM = "FORM";
    localparam logic [31:0] TAG_AIFF = "AIFF";
    localparam logic [31:0] TAG_COMM = "COMM";
    localparam logic [31:0] TAG_SSND = "SSND";
    localparam logic [31:0] TAG_SND  = ".snd";
    localparam logic [31:0] TAG_DNS  = "dns.";

    localparam logic [31:0] WAVE_HDR = 32'd44;
    localparam logic [31:0] AIFF_HDR = 32'd54;

    typedef struct packed {
        logic              cap;
        logic              cap_last;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              parse_en;
        logic              mul1_en;
        logic              mul2_en;
        logic              fin_en;
    } t_cmd;

    function automatic logic [2:0] bits_to_bytes(input logic [15:0] bits);
        logic [2:0] res;
        case (bits)
            16'd16:  res = 3'd2;
            16'd24:  res = 3'd3;
            16'd32:  res = 3'd4;
            default: res = 3'd0;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/core/afhp_ctrl.sv @@
// Controller state machine: byte capture, store read pass and compute steps.
`include "audio_file_header_parser_defines.svh"

module afhp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output afhp_pkg::t_cmd o_cmd
);
    import afhp_pkg::*;

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_READ    = 3'd1;
    localparam logic [2:0] S_DRAIN   = 3'd2;
    localparam logic [2:0] S_PARSE   = 3'd3;
    localparam logic [2:0] S_MUL1    = 3'd4;
    localparam logic [2:0] S_MUL2    = 3'd5;
    localparam logic [2:0] S_FINAL   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_out_valid, n_out_valid;
    logic              accept;

    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_COLLECT: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    o_cmd.cap      = 1'b1;
                    o_cmd.cap_last = i_in_last;
                    if (i_in_last) begin
                        n_state = S_READ;
                        n_addr  = '0;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_addr;
                n_addr        = r_addr + 1'b1;
                if (r_addr == RD_LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_PARSE;
            end
            S_PARSE: begin
                o_cmd.parse_en = 1'b1;
                n_state        = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1_en = 1'b1;
                n_state       = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2_en = 1'b1;
                n_state       = S_FINAL;
            end
            S_FINAL: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fin_en = 1'b1;
                    n_state      = S_COLLECT;
                end
            end
            default: begin
                n_state = S_COLLECT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.fin_en) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `AFHP_ASSERT_NEXT(a_last_starts_read, i_clk, i_rst_n, accept && i_in_last, r_state == S_READ)
    `AFHP_ASSERT_NOW(a_read_addr_range, i_clk, i_rst_n, r_state == S_READ, r_addr <= RD_LAST)
    `AFHP_ASSERT_NEXT(a_fin_sets_valid, i_clk, i_rst_n, o_cmd.fin_en, r_out_valid)
    `AFHP_ASSERT_NEXT(a_read_end_drain, i_clk, i_rst_n,
        (r_state == S_READ) && (r_addr == RD_LAST), r_state == S_DRAIN)

endmodule

@@ rtl/core/afhp_dp.sv @@
// Datapath: header store, byte count, read window, field decode and arithmetic.
module afhp_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  afhp_pkg::t_cmd              i_cmd,
    input  logic [7:0]                  i_byte,
    input  logic                        i_cfg_wr_en,
    input  logic [23:0]                 i_cfg_wr_data,
    output logic [afhp_pkg::OUT_W-1:0]  o_result
);
    import afhp_pkg::*;

    logic [7:0]         mem [HEADER_CAPTURE];
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] r_n;
    logic [COUNT_W-1:0] count_inc;
    logic [7:0]         r_rd_data;
    logic               r_rd_vld;
    logic [WIN_BYTES*8-1:0] r_win;
    logic [7:0]         w [WIN_BYTES];
    logic [23:0]        r_onset;

    logic        n_ok;
    logic [1:0]  n_kind;
    logic        n_be;
    logic [2:0]  n_sb;
    logic [31:0] n_ch, n_hdr, n_size;

    logic        r_ok;
    logic [1:0]  r_kind;
    logic        r_be;
    logic [2:0]  r_sb;
    logic [31:0] r_ch, r_hdr, r_size;
    logic [34:0] r_chsb;
    logic [58:0] r_skip;
    logic [58:0] rem_wide;

    logic        r_out_ok;
    logic [1:0]  r_out_kind;
    logic        r_out_be;
    logic [2:0]  r_out_sb;
    logic [31:0] r_out_ch, r_out_hdr, r_out_rem;
    logic [59:0] r_out_start;

    logic [31:0] tag0, tag8, tag12, tag36, tag38;
    logic [15:0] wav_code, wav_bits, wav_ch, aif_bits, aif_ch;
    logic [31:0] wav_size, aif_chunk, nxt_enc, nxt_hdr, nxt_ch, nxt_size;
    logic [2:0]  wav_sb, aif_sb, nxt_sb;

    assign count_inc = (r_count < COUNT_MAX) ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap && (r_count < COUNT_W'(HEADER_CAPTURE))) begin
            mem[r_count[ADDR_W-1:0]] <= i_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_onset  <= '0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cfg_wr_en) begin
                r_onset <= i_cfg_wr_data;
            end
            if (i_cmd.cap) begin
                r_count <= i_cmd.cap_last ? '0 : count_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap && i_cmd.cap_last) begin
            r_n <= count_inc;
        end
        if (r_rd_vld) begin
            r_win <= {r_win[WIN_BYTES*8-9:0], r_rd_data};
        end
    end

    always_comb begin
        for (int k = 0; k < WIN_BYTES; k++) begin
            w[k] = r_win[(WIN_BYTES-1-k)*8 +: 8];
        end
    end

    assign tag0      = {w[0], w[1], w[2], w[3]};
    assign tag8      = {w[8], w[9], w[10], w[11]};
    assign tag12     = {w[12], w[13], w[14], w[15]};
    assign tag36     = {w[36], w[37], w[38], w[39]};
    assign tag38     = {w[38], w[39], w[40], w[41]};
    assign wav_code  = {w[21], w[20]};
    assign wav_ch    = {w[23], w[22]};
    assign wav_bits  = {w[35], w[34]};
    assign wav_size  = {w[43], w[42], w[41], w[40]};
    assign aif_ch    = {w[20], w[21]};
    assign aif_bits  = {w[26], w[27]};
    assign aif_chunk = {w[42], w[43], w[44], w[45]};
    assign wav_sb    = bits_to_bytes(wav_bits);
    assign aif_sb    = bits_to_bytes(aif_bits);

    always_comb begin
        n_kind = FMT_NONE;
        n_be   = 1'b0;
        if (r_n >= 6'd4) begin
            if (tag0 == TAG_SND) begin
                n_kind = FMT_NEXT;
                n_be   = 1'b1;
            end else if (tag0 == TAG_DNS) begin
                n_kind = FMT_NEXT;
            end else if (r_n >= 6'd12) begin
                if ((tag0 == TAG_RIFF) && (tag8 == TAG_WAVE)) begin
                    n_kind = FMT_WAVE;
                end else if ((tag0 == TAG_FORM) && (tag8 == TAG_AIFF)) begin
                    n_kind = FMT_AIFF;
                    n_be   = 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (n_be) begin
            nxt_enc  = {w[12], w[13], w[14], w[15]};
            nxt_hdr  = {w[4], w[5], w[6], w[7]};
            nxt_ch   = {w[20], w[21], w[22], w[23]};
            nxt_size = {w[8], w[9], w[10], w[11]};
        end else begin
            nxt_enc  = {w[15], w[14], w[13], w[12]};
            nxt_hdr  = {w[7], w[6], w[5], w[4]};
            nxt_ch   = {w[23], w[22], w[21], w[20]};
            nxt_size = {w[11], w[10], w[9], w[8]};
        end
        case (nxt_enc)
            32'd3:   nxt_sb = 3'd2;
            32'd4:   nxt_sb = 3'd3;
            32'd6:   nxt_sb = 3'd4;
            default: nxt_sb = 3'd0;
        endcase
    end

    always_comb begin
        n_ok   = 1'b0;
        n_sb   = '0;
        n_ch   = '0;
        n_hdr  = '0;
        n_size = '0;
        if ((n_kind == FMT_WAVE) && (r_n > 6'd44) && (tag12 == TAG_FMT)
                && (tag36 == TAG_DATA)) begin
            if (((wav_code == 16'd1) || (wav_code == 16'd3)) && (wav_sb != 3'd0)) begin
                n_ok   = 1'b1;
                n_sb   = wav_sb;
                n_ch   = {16'b0, wav_ch};
                n_hdr  = WAVE_HDR;
                n_size = wav_size;
            end
        end else if ((n_kind == FMT_AIFF) && (r_n > 6'd54) && (tag12 == TAG_COMM)
                && (tag38 == TAG_SSND)) begin
            if (aif_sb != 3'd0) begin
                n_ok   = 1'b1;
                n_sb   = aif_sb;
                n_ch   = {16'b0, aif_ch};
                n_hdr  = AIFF_HDR;
                n_size = (aif_chunk > 32'd8) ? aif_chunk - 32'd8 : 32'd0;
            end
        end else if ((n_kind == FMT_NEXT) && (r_n > 6'd28)) begin
            if (nxt_sb != 3'd0) begin
                n_ok   = 1'b1;
                n_sb   = nxt_sb;
                n_ch   = nxt_ch;
                n_hdr  = nxt_hdr;
                n_size = nxt_size;
            end
        end
    end

    assign rem_wide = {27'b0, r_size} - r_skip;

    always_ff @(posedge i_clk) begin
        if (i_cmd.parse_en) begin
            r_ok   <= n_ok;
            r_kind <= n_kind;
            r_be   <= n_be;
            r_sb   <= n_sb;
            r_ch   <= n_ch;
            r_hdr  <= n_hdr;
            r_size <= n_size;
        end
        if (i_cmd.mul1_en) begin
            r_chsb <= {3'b0, r_ch} * {32'b0, r_sb};
        end
        if (i_cmd.mul2_en) begin
            r_skip <= {24'b0, r_chsb} * {35'b0, r_onset};
        end
        if (i_cmd.fin_en) begin
            r_out_ok    <= r_ok;
            r_out_kind  <= r_kind;
            r_out_be    <= r_be;
            r_out_sb    <= r_sb;
            r_out_ch    <= r_ch;
            r_out_hdr   <= r_hdr;
            r_out_start <= {28'b0, r_hdr} + {1'b0, r_skip};
            r_out_rem   <= ({27'b0, r_size} > r_skip) ? rem_wide[31:0] : 32'd0;
        end
    end

    assign o_result = {5'b0, r_out_rem, r_out_start, r_out_hdr, r_out_ch,
                       r_out_sb, r_out_be, r_out_kind, r_out_ok};

endmodule

@@ rtl/core/audio_file_header_parser.sv @@
// Top level of the sound file header parser (WAVE, AIFF, NeXT/Sun).
//
//  channel  | direction | payload
//  s_axis   | in        | tdata[7:0] header byte, tlast marks the final byte
//  m_axis   | out       | tdata: one parsed header result per final byte
//  cfg      | in        | 24-bit onset in frames, written on i_cfg_wr_en
//
// A byte without tlast is accepted; the first 54 bytes go to the header store.
// A byte with tlast holds s_axis_tready low through a read pass of the header
// store port, a drain step, one decode step and two multiply steps, and a final
// step that waits while the previous result is still not taken.
// The next file's bytes are accepted while a finished result waits on m_axis.
// Reset is synchronous and active low; the header store is not cleared.
module audio_file_header_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: header_byte[7:0]
    input  logic [7:0]   s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: ok[0], format_kind[2:1], big_endian[3], sample_bytes[6:4],
    // channel_count[38:7], header_bytes[70:39], data_start[130:71],
    // data_remaining[162:131], zero fill[167:163]
    output logic [167:0] m_axis_tdata,
    input  logic         i_cfg_wr_en,
    input  logic [23:0]  i_cfg_wr_data
);
    import afhp_pkg::*;

    t_cmd cmd;

    afhp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (cmd)
    );

    afhp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_byte        (s_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (m_axis_tdata)
    );

endmodule
